FILE: rtl/rtcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rtcm_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int NIBBLE        = 4;
   localparam int DEC_SCALE     = 10;
   localparam int PHASE_W       = 3;
   localparam int INDEX_W       = 3;

   localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_CMD   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_WDATA = 3'd2;
   localparam logic [PHASE_W-1:0] PH_READ  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_END   = 3'd4;

   localparam logic [INDEX_W-1:0] LAST_BIT = INDEX_W'(BITS_PER_BYTE - 1);

   typedef struct packed {
      logic       start_req;
      logic       func;
      logic [7:0] command_byte;
      logic [7:0] write_data;
      logic       io_sample;
   } req_type;

   typedef struct packed {
      logic       chip_enable_out;
      logic       serial_clock_out;
      logic       data_out;
      logic       data_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_value;
   } rsp_type;

   // tens nibble * 10 + units nibble, as (tens << 3) + (tens << 1) + units
   function automatic logic [7:0] bcd_convert(input logic [7:0] raw);
      logic [NIBBLE-1:0] tens;
      logic [NIBBLE-1:0] units;
      tens  = raw[7:NIBBLE];
      units = raw[NIBBLE-1:0];
      return 8'({tens, 3'b000}) + 8'({tens, 1'b0}) + 8'(units);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/rtcm_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rtcm_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic       func;
   logic [7:0] command_byte;
   logic [7:0] write_data;
   logic       io_sample;

   modport source (output valid, start_req, func, command_byte, write_data, io_sample,
                   input ready);
   modport sink   (input valid, start_req, func, command_byte, write_data, io_sample,
                   output ready);
endinterface

interface rtcm_rsp_if;
   logic       valid;
   logic       ready;
   logic       chip_enable_out;
   logic       serial_clock_out;
   logic       data_out;
   logic       data_drive;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_value;

   modport source (output valid, chip_enable_out, serial_clock_out, data_out, data_drive,
                   busy_res, done_res, read_value, input ready);
   modport sink   (input valid, chip_enable_out, serial_clock_out, data_out, data_drive,
                   busy_res, done_res, read_value, output ready);
endinterface

interface rtcm_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/three_wire_rtc_register_master.sv
`timescale 1ns / 1ps
`default_nettype none
// Three-wire real-time-clock register master. Each request transfer is one half-bit
// tick of the serial bus and yields exactly one response transfer carrying the line
// levels for that tick plus busy/done status and, on the done tick of a read, the read
// byte (optionally BCD-to-decimal converted per the csr bit, which resets to 1).
// A request is accepted whenever the output register is empty or being drained, and
// its response is captured in that register as it is accepted, so throughput is one
// tick per clock while rsp_ch.ready is high. Write csr only while no transfer is busy.
module three_wire_rtc_register_master (
   input wire logic   clock,
   input wire logic   reset,
   rtcm_req_if.sink   req_ch,
   rtcm_rsp_if.source rsp_ch,
   rtcm_csr_if.sink   csr_ch
);
   import rtcm_pkg::*;

   logic    bcd_enable_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type step_rsp;
   req_type req_data;
   logic    advance;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign req_data.start_req    = req_ch.start_req;
   assign req_data.func         = req_ch.func;
   assign req_data.command_byte = req_ch.command_byte;
   assign req_data.write_data   = req_ch.write_data;
   assign req_data.io_sample    = req_ch.io_sample;

   rtcm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .bcd_enable (bcd_enable_ff),
      .req        (req_data),
      .rsp        (step_rsp)
   );

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         bcd_enable_ff <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            bcd_enable_ff <= csr_ch.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.chip_enable_out  = rsp_data_ff.chip_enable_out;
   assign rsp_ch.serial_clock_out = rsp_data_ff.serial_clock_out;
   assign rsp_ch.data_out         = rsp_data_ff.data_out;
   assign rsp_ch.data_drive       = rsp_data_ff.data_drive;
   assign rsp_ch.busy_res         = rsp_data_ff.busy_res;
   assign rsp_ch.done_res         = rsp_data_ff.done_res;
   assign rsp_ch.read_value       = rsp_data_ff.read_value;

endmodule
`default_nettype wire

FILE: rtl/rtcm_core.sv
`timescale 1ns / 1ps
`default_nettype none
module rtcm_core (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic advance,
   input  wire                logic bcd_enable,
   input  wire rtcm_pkg::req_type   req,
   output rtcm_pkg::rsp_type        rsp
);
   import rtcm_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [INDEX_W-1:0] bit_index_ff, bit_index_in;
   logic               half_ff, half_in;
   logic [7:0]         cmd_shift_ff, cmd_shift_in;
   logic [7:0]         data_shift_ff, data_shift_in;
   logic [7:0]         read_shift_ff, read_shift_in;
   logic               write_mode_ff, write_mode_in;
   logic [7:0]         last_read_ff, last_read_in;

   logic               last;
   logic [7:0]         sh_cur;
   logic [7:0]         sh_next;
   logic               dout;
   logic               drive;

   always_comb begin
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      half_in       = half_ff;
      cmd_shift_in  = cmd_shift_ff;
      data_shift_in = data_shift_ff;
      read_shift_in = read_shift_ff;
      write_mode_in = write_mode_ff;
      last_read_in  = last_read_ff;

      last    = (bit_index_ff == LAST_BIT);
      sh_cur  = (phase_ff == PH_CMD) ? cmd_shift_ff : data_shift_ff;
      sh_next = sh_cur >> 1;
      dout    = 1'b0;
      drive   = 1'b0;

      rsp = '0;
      rsp.chip_enable_out = 1'b1;
      rsp.busy_res        = 1'b1;

      unique case (phase_ff) inside
         PH_CMD, PH_WDATA: begin
            drive = 1'b1;
            if (!half_ff) begin
               rsp.serial_clock_out = 1'b1;
               dout    = sh_cur[0];
               half_in = 1'b1;
            end else begin
               half_in = 1'b0;
               if (phase_ff == PH_CMD) begin
                  cmd_shift_in = sh_next;
               end else begin
                  data_shift_in = sh_next;
               end
               if (!last) begin
                  bit_index_in = bit_index_ff + 1'b1;
                  dout         = sh_next[0];
               end else if (phase_ff == PH_CMD && write_mode_ff) begin
                  phase_in     = PH_WDATA;
                  bit_index_in = '0;
                  dout         = data_shift_ff[0];
               end else if (phase_ff == PH_CMD) begin
                  phase_in      = PH_READ;
                  bit_index_in  = '0;
                  read_shift_in = '0;
                  drive         = 1'b0;
               end else begin
                  phase_in     = PH_END;
                  bit_index_in = '0;
               end
            end
         end
         PH_READ: begin
            if (!half_ff) begin
               rsp.serial_clock_out = 1'b1;
               read_shift_in = {req.io_sample, read_shift_ff[7:1]};
               half_in       = 1'b1;
            end else begin
               half_in = 1'b0;
               if (!last) begin
                  bit_index_in = bit_index_ff + 1'b1;
               end else begin
                  last_read_in = bcd_enable ? bcd_convert(read_shift_ff) : read_shift_ff;
                  phase_in     = PH_END;
                  bit_index_in = '0;
               end
            end
         end
         PH_END: begin
            rsp.chip_enable_out = 1'b0;
            rsp.busy_res        = 1'b0;
            rsp.done_res        = 1'b1;
            rsp.read_value      = write_mode_ff ? 8'd0 : last_read_ff;
            phase_in            = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
            if (req.start_req) begin
               write_mode_in = req.func;
               cmd_shift_in  = req.command_byte;
               data_shift_in = req.write_data;
               bit_index_in  = '0;
               half_in       = 1'b0;
               phase_in      = PH_CMD;
               drive         = 1'b1;
               dout          = req.command_byte[0];
            end else begin
               rsp.chip_enable_out = 1'b0;
               rsp.busy_res        = 1'b0;
            end
         end
      endcase

      rsp.data_drive = drive;
      rsp.data_out   = drive & dout;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_index_ff  <= '0;
         half_ff       <= 1'b0;
         cmd_shift_ff  <= '0;
         data_shift_ff <= '0;
         read_shift_ff <= '0;
         write_mode_ff <= 1'b0;
         last_read_ff  <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         bit_index_ff  <= bit_index_in;
         half_ff       <= half_in;
         cmd_shift_ff  <= cmd_shift_in;
         data_shift_ff <= data_shift_in;
         read_shift_ff <= read_shift_in;
         write_mode_ff <= write_mode_in;
         last_read_ff  <= last_read_in;
      end
   end

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import rtcm_pkg::*;

   localparam int TICKS_PER_XFER    = 34;
   localparam int FIRST_SAMPLE_TICK = 17;
   localparam int LAST_SAMPLE_TICK  = FIRST_SAMPLE_TICK + 2 * (BITS_PER_BYTE - 1);
   localparam int PHASE_TICKS       = 100;
   localparam int LONG_HOLD         = 80;
   localparam int QUIET_LIMIT       = 2000;
   localparam int END_CYCLES        = 10;

   class rtc_tick_scoreboard;
      bit                 bcd_mode;
      logic [PHASE_W-1:0] seq_phase;
      logic [INDEX_W-1:0] bit_pos;
      bit                 second_half;
      bit [7:0]           cmd_sr;
      bit [7:0]           wr_sr;
      bit [7:0]           rd_sr;
      bit [7:0]           held_read;
      bit                 writing;
      rsp_type            expected_lines[$];
      int                 errors;

      function new();
         bcd_mode    = 1'b1;
         seq_phase   = PH_IDLE;
         bit_pos     = '0;
         second_half = 1'b0;
         cmd_sr      = '0;
         wr_sr       = '0;
         rd_sr       = '0;
         held_read   = '0;
         writing     = 1'b0;
         errors      = 0;
      endfunction

      function bit [7:0] to_decimal(input bit [7:0] raw);
         return 8'(raw[7:NIBBLE] * DEC_SCALE + raw[NIBBLE-1:0]);
      endfunction

      function void note_tick(input req_type r);
         rsp_type e;
         bit      last_bit;
         bit      on_cmd;
         e = '0;
         e.chip_enable_out = 1'b1;
         e.busy_res = 1'b1;
         last_bit = (bit_pos == LAST_BIT);
         on_cmd = (seq_phase == PH_CMD);
         case (seq_phase)
            PH_CMD, PH_WDATA: begin
               e.data_drive = 1'b1;
               if (!second_half) begin
                  e.serial_clock_out = 1'b1;
                  e.data_out = on_cmd ? cmd_sr[0] : wr_sr[0];
                  second_half = 1'b1;
               end else begin
                  second_half = 1'b0;
                  if (on_cmd) cmd_sr = cmd_sr >> 1;
                  else wr_sr = wr_sr >> 1;
                  if (!last_bit) begin
                     bit_pos = bit_pos + 1'b1;
                     e.data_out = on_cmd ? cmd_sr[0] : wr_sr[0];
                  end else begin
                     bit_pos = '0;
                     if (on_cmd && writing) begin
                        seq_phase = PH_WDATA;
                        e.data_out = wr_sr[0];
                     end else if (on_cmd) begin
                        seq_phase = PH_READ;
                        rd_sr = '0;
                        e.data_drive = 1'b0;
                     end else begin
                        seq_phase = PH_END;
                     end
                  end
               end
            end
            PH_READ: begin
               if (!second_half) begin
                  e.serial_clock_out = 1'b1;
                  rd_sr = {r.io_sample, rd_sr[7:1]};
                  second_half = 1'b1;
               end else begin
                  second_half = 1'b0;
                  if (!last_bit) begin
                     bit_pos = bit_pos + 1'b1;
                  end else begin
                     held_read = bcd_mode ? to_decimal(rd_sr) : rd_sr;
                     seq_phase = PH_END;
                     bit_pos = '0;
                  end
               end
            end
            PH_END: begin
               e.chip_enable_out = 1'b0;
               e.busy_res = 1'b0;
               e.done_res = 1'b1;
               e.read_value = writing ? 8'h00 : held_read;
               seq_phase = PH_IDLE;
            end
            default: begin
               seq_phase = PH_IDLE;
               if (r.start_req) begin
                  writing = r.func;
                  cmd_sr = r.command_byte;
                  wr_sr = r.write_data;
                  bit_pos = '0;
                  second_half = 1'b0;
                  seq_phase = PH_CMD;
                  e.data_drive = 1'b1;
                  e.data_out = r.command_byte[0];
               end else begin
                  e.chip_enable_out = 1'b0;
                  e.busy_res = 1'b0;
               end
            end
         endcase
         expected_lines.push_back(e);
      endfunction

      task report_mismatch(input string msg);
         errors++;
         $display("%0t ERROR: %s", $time, msg);
      endtask

      task compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_tick(input rsp_type got);
         rsp_type want;
         if (expected_lines.size() == 0) begin
            report_mismatch("response transfer with nothing expected");
            return;
         end
         want = expected_lines.pop_front();
         compare_field("chip_enable_out", 8'(got.chip_enable_out),
                       8'(want.chip_enable_out));
         compare_field("serial_clock_out", 8'(got.serial_clock_out),
                       8'(want.serial_clock_out));
         compare_field("data_out", 8'(got.data_out), 8'(want.data_out));
         compare_field("data_drive", 8'(got.data_drive), 8'(want.data_drive));
         compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
         compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
         compare_field("read_value", got.read_value, want.read_value);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   bit   long_hold_req = 1'b0;
   int   quiet_cycles = 0;

   rtc_tick_scoreboard sb = new();

   rtcm_req_if req_ch();
   rtcm_rsp_if rsp_ch();
   rtcm_csr_if csr_ch();

   three_wire_rtc_register_master dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin : rsp_sink
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      req_type tick;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.chip_enable_out  = rsp_ch.chip_enable_out;
            got.serial_clock_out = rsp_ch.serial_clock_out;
            got.data_out         = rsp_ch.data_out;
            got.data_drive       = rsp_ch.data_drive;
            got.busy_res         = rsp_ch.busy_res;
            got.done_res         = rsp_ch.done_res;
            got.read_value       = rsp_ch.read_value;
            sb.check_tick(got);
         end
         if (req_ch.valid && req_ch.ready) begin
            tick.start_req    = req_ch.start_req;
            tick.func         = req_ch.func;
            tick.command_byte = req_ch.command_byte;
            tick.write_data   = req_ch.write_data;
            tick.io_sample    = req_ch.io_sample;
            sb.note_tick(tick);
         end
         if (csr_ch.valid && csr_ch.ready) sb.bcd_mode = csr_ch.data;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_tick(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.start_req    <= r.start_req;
      req_ch.func         <= r.func;
      req_ch.command_byte <= r.command_byte;
      req_ch.write_data   <= r.write_data;
      req_ch.io_sample    <= r.io_sample;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_lines.size() != 0);
   endtask

   task automatic write_bcd(input bit value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic idle_tick();
      req_type r;
      r = req_type'($urandom);
      r.start_req = 1'b0;
      send_tick(r);
   endtask

   // line_byte is the level presented on the data line at each read sample point
   task automatic run_transfer(input bit wr, input bit [7:0] cmd, input bit [7:0] wdata,
                               input bit [7:0] line_byte, input int restart_pct);
      req_type r;
      for (int t = 0; t < TICKS_PER_XFER; t++) begin
         r = req_type'($urandom);
         r.start_req = (t == 0) || ($urandom_range(99) < restart_pct);
         if (t == 0) begin
            r.func = wr;
            r.command_byte = cmd;
            r.write_data = wdata;
         end
         if (t >= FIRST_SAMPLE_TICK && t <= LAST_SAMPLE_TICK && (t - FIRST_SAMPLE_TICK) % 2 == 0)
            r.io_sample = line_byte[(t - FIRST_SAMPLE_TICK) / 2];
         send_tick(r);
      end
   endtask

   task automatic random_transfer();
      bit [7:0] line_byte;
      int       restart_pct;
      case ($urandom_range(7))
         0: line_byte = 8'hFF;
         1: line_byte = 8'h00;
         2, 3: line_byte = {4'($urandom_range(9)), 4'($urandom_range(9))};
         default: line_byte = 8'($urandom);
      endcase
      case ($urandom_range(3))
         0: restart_pct = 0;
         1: restart_pct = 100;
         default: restart_pct = 30;
      endcase
      run_transfer(1'($urandom), 8'($urandom), 8'($urandom), line_byte, restart_pct);
   endtask

   task automatic run_phase(input int send_pct, input int stall_pct, input bit bcd,
                            input bit pressure);
      int sent;
      int xfers;
      drain_results();
      write_bcd(bcd);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      xfers = 0;
      while (sent < PHASE_TICKS) begin
         if (pressure && xfers == 0) long_hold_req = 1'b1;
         if (pressure && xfers == 2) drain_results();
         repeat ($urandom_range(2)) begin
            idle_tick();
            sent++;
         end
         random_transfer();
         sent += TICKS_PER_XFER;
         xfers++;
      end
   endtask

   initial begin
      req_type r;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.start_req    <= 1'b0;
      req_ch.func         <= 1'b0;
      req_ch.command_byte <= '0;
      req_ch.write_data   <= '0;
      req_ch.io_sample    <= 1'b0;
      csr_ch.valid        <= 1'b0;
      csr_ch.data         <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      r = '0;
      send_tick(r);
      r = '1;
      r.start_req = 1'b0;
      send_tick(r);
      run_transfer(1'b0, 8'hFF, 8'hFF, 8'hFF, 100);
      run_transfer(1'b1, 8'h00, 8'hFF, 8'h00, 0);
      run_transfer(1'b0, 8'h81, 8'h00, 8'h99, 30);

      run_phase(0, 0, 1'b0, 1'b1);
      run_phase(55, 0, 1'b1, 1'b0);
      run_phase(0, 55, 1'b0, 1'b0);
      run_phase(34, 34, 1'($urandom), 1'b0);

      drain_results();
      repeat (END_CYCLES) @(posedge clock);
      if (sb.errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/rtcm_pkg.sv
rtl/rtcm_if.sv
rtl/rtcm_core.sv
rtl/three_wire_rtc_register_master.sv
dv/tb_top.sv
